>>> sv/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants for the shallow-water wave speed unit.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int Q_FRAC   = 16;
    localparam int WORD_W   = 32;
    localparam int GRAV_W   = 24;
    localparam int DIV_W    = WORD_W + Q_FRAC;
    localparam int PROD_W   = 56;
    localparam int ROOT_W   = PROD_W / 2;
    localparam int LANE_LAT = DIV_W + 2;

    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 24'd642908;
    localparam logic [WORD_W-1:0] S32_MAX       = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] S32_MIN       = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] left_depth;
        logic signed [31:0] left_momentum;
        logic signed [31:0] right_depth;
        logic signed [31:0] right_momentum;
    } sws_cell_t;

    typedef struct packed {
        logic signed [31:0] left_slow;
        logic signed [31:0] left_mid;
        logic signed [31:0] left_fast;
        logic signed [31:0] right_slow;
        logic signed [31:0] right_mid;
        logic signed [31:0] right_fast;
        logic signed [31:0] center_slow;
        logic signed [31:0] center_mid;
        logic signed [31:0] center_fast;
        logic               well_defined;
        logic               divide_fault;
    } sws_speed_t;

    typedef struct packed {
        logic signed [31:0] depth;
        logic signed [31:0] momentum;
    } sws_state_t;

    typedef struct packed {
        sws_state_t left;
        sws_state_t right;
        sws_state_t center;
    } sws_work_t;

    typedef struct packed {
        logic               valid;
        sws_work_t          work;
    } sws_push_t;

    typedef struct packed {
        logic signed [31:0] slow;
        logic signed [31:0] mid;
        logic signed [31:0] fast;
        logic               neg;
        logic               divz;
    } sws_lane_res_t;

endpackage

>>> sv/sws_cell_if.sv
// ----------------------------------------------------------------------------
// sws_cell_if
// Valid/ready channel carrying one pair of neighboring cells.
// ----------------------------------------------------------------------------
interface sws_cell_if;
    import sws_pkg::*;

    logic      valid;
    logic      ready;
    sws_cell_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> sv/sws_speed_if.sv
// ----------------------------------------------------------------------------
// sws_speed_if
// Valid/ready channel carrying the eigenvalues and flags of one interface.
// ----------------------------------------------------------------------------
interface sws_speed_if;
    import sws_pkg::*;

    logic       valid;
    logic       ready;
    sws_speed_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> sv/sws_front.sv
// ----------------------------------------------------------------------------
// sws_front
// Accepts cell pairs and forms the averaged interface state.
// ----------------------------------------------------------------------------
module sws_front
    import sws_pkg::*;
(
    sws_cell_if.sink    cells,
    input  logic        queue_full,
    output sws_push_t   push
);

    logic signed [32:0] depth_sum;
    logic signed [32:0] mom_sum;

    always_comb
    begin
        depth_sum = 33'(cells.data.left_depth) + 33'(cells.data.right_depth);
        mom_sum   = 33'(cells.data.left_momentum) + 33'(cells.data.right_momentum);
    end

    assign cells.ready = !queue_full;

    always_comb
    begin
        push.valid                = cells.valid && !queue_full;
        push.work.left.depth      = cells.data.left_depth;
        push.work.left.momentum   = cells.data.left_momentum;
        push.work.right.depth     = cells.data.right_depth;
        push.work.right.momentum  = cells.data.right_momentum;
        push.work.center.depth    = depth_sum[32:1];
        push.work.center.momentum = mom_sum[32:1];
    end

endmodule

>>> sv/sws_queue.sv
// ----------------------------------------------------------------------------
// sws_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module sws_queue
    import sws_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  sws_push_t push,
    output logic      full,
    input  logic      pop,
    output logic      avail,
    output sws_work_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sws_work_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_pop;

    assign full   = (count_reg == CW'(DEPTH));
    assign avail  = (count_reg != '0);
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && avail;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.work;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push.valid && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push.valid && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/sws_lane.sv
// ----------------------------------------------------------------------------
// sws_lane
// Pipelined velocity divider and celerity root for one state, one bit a stage.
// ----------------------------------------------------------------------------
module sws_lane
    import sws_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  sws_state_t        state,
    input  logic [GRAV_W-1:0] gravity,
    output sws_lane_res_t     res
);

    logic [DIV_W-1:0]  nq_reg   [DIV_W+1];
    logic [WORD_W-1:0] rem_reg  [DIV_W+1];
    logic [WORD_W-1:0] den_reg  [DIV_W+1];
    logic [PROD_W-1:0] x_reg    [DIV_W+1];
    logic [ROOT_W+1:0] sr_reg   [DIV_W+1];
    logic [ROOT_W-1:0] root_reg [DIV_W+1];
    logic              dz_reg   [DIV_W+1];
    logic              sgn_reg  [DIV_W+1];
    logic              mpos_reg [DIV_W+1];
    logic              mneg_reg [DIV_W+1];
    logic              neg_reg  [DIV_W+1];

    logic [WORD_W-1:0] dabs;
    logic [WORD_W-1:0] mabs;

    always_comb
    begin
        dabs = state.depth[31] ? WORD_W'(-state.depth) : WORD_W'(state.depth);
        mabs = state.momentum[31] ? WORD_W'(-state.momentum) : WORD_W'(state.momentum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg[0]   <= {mabs, {Q_FRAC{1'b0}}};
            rem_reg[0]  <= '0;
            den_reg[0]  <= dabs;
            x_reg[0]    <= state.depth[31] ? '0
                         : PROD_W'(gravity) * PROD_W'(state.depth[30:0]);
            sr_reg[0]   <= '0;
            root_reg[0] <= '0;
            dz_reg[0]   <= (state.depth == '0);
            sgn_reg[0]  <= state.momentum[31] ^ state.depth[31];
            mpos_reg[0] <= !state.momentum[31] && (state.momentum != '0);
            mneg_reg[0] <= state.momentum[31];
            neg_reg[0]  <= state.depth[31];
        end
    end

    for (genvar k = 0; k < DIV_W; k++)
    begin : g_step
        logic [WORD_W:0]   t;
        logic              ge;
        logic [WORD_W:0]   diff;
        logic [ROOT_W+3:0] r2;
        logic [ROOT_W+3:0] trial;
        logic              ge2;
        logic [ROOT_W+3:0] diff2;

        always_comb
        begin
            t     = {rem_reg[k], nq_reg[k][DIV_W-1]};
            ge    = (t >= {1'b0, den_reg[k]});
            diff  = t - {1'b0, den_reg[k]};
            r2    = {sr_reg[k], x_reg[k][PROD_W-1:PROD_W-2]};
            trial = {2'b00, root_reg[k], 2'b01};
            ge2   = (r2 >= trial);
            diff2 = r2 - trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? diff[WORD_W-1:0] : t[WORD_W-1:0];
                nq_reg[k+1]   <= {nq_reg[k][DIV_W-2:0], ge};
                den_reg[k+1]  <= den_reg[k];
                dz_reg[k+1]   <= dz_reg[k];
                sgn_reg[k+1]  <= sgn_reg[k];
                mpos_reg[k+1] <= mpos_reg[k];
                mneg_reg[k+1] <= mneg_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                if (k < ROOT_W)
                begin
                    sr_reg[k+1]   <= ge2 ? diff2[ROOT_W+1:0] : r2[ROOT_W+1:0];
                    root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], ge2};
                    x_reg[k+1]    <= {x_reg[k][PROD_W-3:0], 2'b00};
                end
                else
                begin
                    sr_reg[k+1]   <= sr_reg[k];
                    root_reg[k+1] <= root_reg[k];
                    x_reg[k+1]    <= x_reg[k];
                end
            end
        end
    end

    logic [DIV_W-1:0]   q;
    logic signed [33:0] v;
    logic signed [33:0] c;
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic [WORD_W-1:0]  v32;
    logic [WORD_W-1:0]  lo32;
    logic [WORD_W-1:0]  hi32;

    always_comb
    begin
        q = nq_reg[DIV_W];
        if (dz_reg[DIV_W])
        begin
            v = mpos_reg[DIV_W] ? 34'(signed'(S32_MAX))
              : (mneg_reg[DIV_W] ? 34'(signed'(S32_MIN)) : '0);
        end
        else if (sgn_reg[DIV_W])
        begin
            v = (q > DIV_W'(S32_MIN)) ? 34'(signed'(S32_MIN)) : -signed'({2'b00, q[31:0]});
        end
        else
        begin
            v = (q[DIV_W-1:31] != '0) ? 34'(signed'(S32_MAX)) : signed'({2'b00, q[31:0]});
        end
        c  = signed'(34'(root_reg[DIV_W]));
        lo = v - c;
        hi = v + c;
        v32 = v[31:0];
        if (lo < 34'(signed'(S32_MIN)))
        begin
            lo32 = S32_MIN;
        end
        else
        begin
            lo32 = lo[31:0];
        end
        if (hi > 34'(signed'(S32_MAX)))
        begin
            hi32 = S32_MAX;
        end
        else
        begin
            hi32 = hi[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res.slow <= signed'(lo32);
            res.mid  <= signed'(v32);
            res.fast <= signed'(hi32);
            res.neg  <= neg_reg[DIV_W];
            res.divz <= dz_reg[DIV_W];
        end
    end

endmodule

>>> sv/sws_back.sv
// ----------------------------------------------------------------------------
// sws_back
// Runs three lanes in lock step and presents the registered result beat.
// ----------------------------------------------------------------------------
module sws_back
    import sws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              avail,
    input  sws_work_t         head,
    output logic              pop,
    input  logic [GRAV_W-1:0] gravity,
    sws_speed_if.source       speeds
);

    logic [LANE_LAT-1:0] valid_reg;
    logic                en;
    sws_lane_res_t       l_res;
    sws_lane_res_t       r_res;
    sws_lane_res_t       c_res;

    assign en  = !valid_reg[LANE_LAT-1] || speeds.ready;
    assign pop = en && avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LANE_LAT-2:0], avail};
        end
    end

    sws_lane u_left   (.clk(clk), .en(en), .state(head.left),   .gravity(gravity), .res(l_res));
    sws_lane u_right  (.clk(clk), .en(en), .state(head.right),  .gravity(gravity), .res(r_res));
    sws_lane u_center (.clk(clk), .en(en), .state(head.center), .gravity(gravity), .res(c_res));

    assign speeds.valid = valid_reg[LANE_LAT-1];

    always_comb
    begin
        speeds.data.left_slow    = l_res.slow;
        speeds.data.left_mid     = l_res.mid;
        speeds.data.left_fast    = l_res.fast;
        speeds.data.right_slow   = r_res.slow;
        speeds.data.right_mid    = r_res.mid;
        speeds.data.right_fast   = r_res.fast;
        speeds.data.center_slow  = c_res.slow;
        speeds.data.center_mid   = c_res.mid;
        speeds.data.center_fast  = c_res.fast;
        speeds.data.well_defined = !(l_res.neg || r_res.neg || c_res.neg);
        speeds.data.divide_fault = l_res.divz || r_res.divz || c_res.divz;
    end

endmodule

>>> sv/shallow_water_wave_speeds_unit.sv
// An accepted cell beat passes the queue, the lane input register, 48 one-bit
//   divider stages (they set the depth) and one saturation stage to its result.
// Throughput: one beat per cycle unless speeds.ready stalls the pipeline.
// Reset: rst_n clears the queue and stage valid bits; gravity returns to 9.81.
// ----------------------------------------------------------------------------
// shallow_water_wave_speeds_unit
// Shallow-water y-direction eigenvalues for left, right and averaged states.
// ----------------------------------------------------------------------------
module shallow_water_wave_speeds_unit
    import sws_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [GRAV_W-1:0] cfg_wdata,
    sws_cell_if.sink          cells,
    sws_speed_if.source       speeds
);

    logic [GRAV_W-1:0] gravity_reg;
    sws_push_t         push;
    logic              full;
    logic              pop;
    logic              avail;
    sws_work_t         head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= GRAVITY_RESET;
        end
        else if (cfg_we)
        begin
            gravity_reg <= cfg_wdata;
        end
    end

    sws_front u_front (.cells(cells), .queue_full(full), .push(push));

    sws_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .pop(pop), .avail(avail), .head(head)
    );

    sws_back u_back
    (
        .clk(clk), .rst_n(rst_n), .avail(avail), .head(head), .pop(pop),
        .gravity(gravity_reg), .speeds(speeds)
    );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams cell pairs into the wave speed unit under several gravity settings
// and idle patterns, predicts the eigenvalues and flags of every beat, and
// checks each result beat field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import sws_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [GRAV_W-1:0] cfg_wdata;

    sws_cell_if  cells ();
    sws_speed_if speeds ();

    shallow_water_wave_speeds_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cells     (cells),
        .speeds    (speeds)
    );

    sws_cell_t         pending_cells[$];
    sws_speed_t        expected_speeds[$];
    logic [GRAV_W-1:0] gravity;
    int                send_idle;
    int                recv_stall;
    int                mismatches;
    logic              cell_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_word(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic void lane_speeds(input longint depth, input longint mom,
                                        output logic signed [31:0] slow,
                                        output logic signed [31:0] mid,
                                        output logic signed [31:0] fast,
                                        inout logic neg, inout logic divz);
        longint v;
        longint c;
        c = 0;
        if (depth == 0)
        begin
            divz = 1'b1;
            v = (mom > 0) ? 64'sd2147483647 : ((mom < 0) ? -64'sd2147483648 : 0);
        end
        else
            v = clamp_word((mom <<< Q_FRAC) / depth);
        if (depth >= 0)
            c = longint'(floor_root(longint'(gravity) * depth));
        else
            neg = 1'b1;
        slow = 32'(clamp_word(v - c));
        mid  = 32'(v);
        fast = 32'(clamp_word(v + c));
    endfunction

    function automatic sws_speed_t wave_speeds(input sws_cell_t c);
        sws_speed_t r;
        logic neg;
        logic divz;
        longint ld;
        longint lm;
        longint rd;
        longint rm;
        neg  = 1'b0;
        divz = 1'b0;
        ld = c.left_depth;
        lm = c.left_momentum;
        rd = c.right_depth;
        rm = c.right_momentum;
        lane_speeds(ld, lm, r.left_slow, r.left_mid, r.left_fast, neg, divz);
        lane_speeds(rd, rm, r.right_slow, r.right_mid, r.right_fast, neg, divz);
        lane_speeds((ld + rd) >>> 1, (lm + rm) >>> 1,
                    r.center_slow, r.center_mid, r.center_fast, neg, divz);
        r.well_defined = ~neg;
        r.divide_fault = divz;
        return r;
    endfunction

    task automatic report(input string field, input longint got, input longint want);
        mismatches++;
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    endtask

    task automatic check_speeds(input sws_speed_t got, input sws_speed_t want);
        if (got.left_slow !== want.left_slow)
            report("left_slow", got.left_slow, want.left_slow);
        if (got.left_mid !== want.left_mid)
            report("left_mid", got.left_mid, want.left_mid);
        if (got.left_fast !== want.left_fast)
            report("left_fast", got.left_fast, want.left_fast);
        if (got.right_slow !== want.right_slow)
            report("right_slow", got.right_slow, want.right_slow);
        if (got.right_mid !== want.right_mid)
            report("right_mid", got.right_mid, want.right_mid);
        if (got.right_fast !== want.right_fast)
            report("right_fast", got.right_fast, want.right_fast);
        if (got.center_slow !== want.center_slow)
            report("center_slow", got.center_slow, want.center_slow);
        if (got.center_mid !== want.center_mid)
            report("center_mid", got.center_mid, want.center_mid);
        if (got.center_fast !== want.center_fast)
            report("center_fast", got.center_fast, want.center_fast);
        if (got.well_defined !== want.well_defined)
            report("well_defined", got.well_defined, want.well_defined);
        if (got.divide_fault !== want.divide_fault)
            report("divide_fault", got.divide_fault, want.divide_fault);
    endtask

    // drive cell beats
    always @(negedge clk)
    begin
        if (rst_n && (!cells.valid || cell_taken))
        begin
            if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                cells.data  <= pending_cells.pop_front();
                cells.valid <= 1'b1;
            end
            else
                cells.valid <= 1'b0;
        end
        if (rst_n)
            speeds.ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        cell_taken <= cells.valid && cells.ready;
        if (cells.valid && cells.ready)
            expected_speeds.push_back(wave_speeds(cells.data));
        if (speeds.valid && speeds.ready)
        begin
            if (expected_speeds.size() == 0)
            begin
                mismatches++;
                $display("unexpected result beat at %0t", $realtime);
            end
            else
                check_speeds(speeds.data, expected_speeds.pop_front());
        end
    end

    function automatic logic signed [31:0] rand_word();
        return $signed($urandom);
    endfunction

    function automatic sws_cell_t gen_cell();
        sws_cell_t c;
        int kind;
        kind = $urandom_range(9);
        c.left_depth     = $urandom_range(24'hFFFFFF, 1) >> $urandom_range(20);
        c.right_depth    = $urandom_range(24'hFFFFFF, 1) >> $urandom_range(20);
        c.left_momentum  = rand_word() >>> $urandom_range(31);
        c.right_momentum = rand_word() >>> $urandom_range(31);
        case (kind)
            6:
            begin
                c.left_depth     = rand_word();
                c.right_depth    = rand_word();
                c.left_momentum  = rand_word();
                c.right_momentum = rand_word();
            end
            7:
            begin
                if ($urandom_range(1))
                    c.left_depth = 0;
                else
                    c.right_depth = 0;
                if ($urandom_range(3) == 0)
                    c.left_momentum = 0;
            end
            8:
            begin
                if ($urandom_range(1))
                    c.left_depth = -c.left_depth;
                else
                    c.right_depth = rand_word() | 32'h8000_0000;
            end
            9:
            begin
                c.right_depth    = -c.left_depth - $urandom_range(1);
                c.right_momentum = -c.left_momentum;
            end
            default:
            begin
            end
        endcase
        return c;
    endfunction

    task automatic add_cell(input logic signed [31:0] ld, input logic signed [31:0] lm,
                            input logic signed [31:0] rd, input logic signed [31:0] rm);
        sws_cell_t c;
        c.left_depth     = ld;
        c.left_momentum  = lm;
        c.right_depth    = rd;
        c.right_momentum = rm;
        pending_cells.push_back(c);
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_cells.size() != 0 || cells.valid || expected_speeds.size() != 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_gravity(input logic [GRAV_W-1:0] g);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(negedge clk);
        cfg_we    <= 1'b0;
        gravity    = g;
    endtask

    initial
    begin
        logic [GRAV_W-1:0] settings[5];
        cells.valid  = 1'b0;
        cells.data   = '0;
        speeds.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        cell_taken   = 1'b0;
        mismatches   = 0;
        send_idle    = 0;
        recv_stall   = 0;
        gravity      = GRAVITY_RESET;
        rst_n        = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_cell(32'h0001_0000, 32'h0002_0000, 32'h0004_0000, -32'sh0001_0000);
        add_cell(0, 32'h0001_0000, 0, -32'sh0001_0000);
        add_cell(0, 0, 32'h0001_0000, 0);
        add_cell(-32'sh0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000);
        add_cell(0, 0, -1, 0);
        add_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_cell(1, 32'h7FFF_FFFF, 1, 32'h8000_0000);
        add_cell(-1, 32'h7FFF_FFFF, 1, 0);
        add_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_cell(32'h0000_8000, 32'h4000_0000, 32'h0000_8000, -32'sh4000_0000);
        add_cell(32'h7FFF_FFFF, 0, 1, 0);
        add_cell(1, 1, -1, -1);

        settings[0] = GRAVITY_RESET;
        settings[1] = 24'hFFFFFF;
        settings[2] = '0;
        settings[3] = 24'd1;
        settings[4] = GRAV_W'($urandom);
        for (int s = 0; s < 5; s++)
        begin
            if (s > 0)
            begin
                write_gravity(settings[s]);
                add_cell(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF);
                add_cell(32'h8000_0000, 1, 32'h0001_0000, -1);
            end
            for (int p = 0; p < 4; p++)
            begin
                case (p)
                    0: begin send_idle = 0;  recv_stall = 0;  end
                    1: begin send_idle = 75; recv_stall = 0;  end
                    2: begin send_idle = 0;  recv_stall = 75; end
                    default: begin send_idle = 34; recv_stall = 34; end
                endcase
                for (int i = 0; i < 80; i++)
                begin
                    pending_cells.push_back(gen_cell());
                    // hold until the pipe empties
                    if (s == 0 && p == 0 && i % 16 == 15)
                        wait_drained();
                end
                wait_drained();
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
